### src/mmm_pkg.sv
package mmm_pkg;

   // arithmetic width of operands, modulus and result
   localparam int WIDTH = 64;
   localparam int LIMB_W = 32;
   localparam int DATA_W = 64;
   localparam int PROD_W = 2 * DATA_W;
   localparam int SUM_W = PROD_W + 1;
   localparam int SHIFT_W = 7;
   localparam int STAGES = 9;

   localparam logic [DATA_W-1:0] WIDTH_MASK =
      (WIDTH >= DATA_W) ? {DATA_W{1'b1}} : ((DATA_W'(1) << WIDTH) - DATA_W'(1));
   localparam logic [SHIFT_W-1:0] WIDTH_K = SHIFT_W'(WIDTH);

   localparam logic [DATA_W-1:0] MODULUS_RESET = DATA_W'(1);
   localparam logic [DATA_W-1:0] MODULUS_INVERSE_RESET = '0;
   localparam logic [SHIFT_W-1:0] SHIFT_BITS_RESET = SHIFT_W'(64);

   typedef enum logic [1:0] {
      CSR_MODULUS         = 2'd0,
      CSR_MODULUS_INVERSE = 2'd1,
      CSR_SHIFT_BITS      = 2'd2
   } csr_index_type;

   // load enables of the two register stages inside a unit
   typedef struct packed {
      logic load_a;
      logic load_b;
   } stage_en_type;

endpackage

### src/mmm_wide_mul.sv
module mmm_wide_mul (
   input  logic                              clock,
   input  mmm_pkg::stage_en_type             stage_en,
   input  logic [mmm_pkg::DATA_W-1:0]        op_x,
   input  logic [mmm_pkg::DATA_W-1:0]        op_y,
   output logic [mmm_pkg::PROD_W-1:0]        product
);

   localparam int LW = mmm_pkg::LIMB_W;
   localparam int DW = mmm_pkg::DATA_W;
   localparam int PW = mmm_pkg::PROD_W;

   logic [DW-1:0] p00_ff, p01_ff, p10_ff, p11_ff;
   logic [DW-1:0] p00_in, p01_in, p10_in, p11_in;
   logic [PW-1:0] product_ff, product_in;

   // four limb products, each its own 32x32 multiplier
   assign p00_in = DW'(op_x[LW-1:0])  * DW'(op_y[LW-1:0]);
   assign p01_in = DW'(op_x[LW-1:0])  * DW'(op_y[DW-1:LW]);
   assign p10_in = DW'(op_x[DW-1:LW]) * DW'(op_y[LW-1:0]);
   assign p11_in = DW'(op_x[DW-1:LW]) * DW'(op_y[DW-1:LW]);

   assign product_in = {{DW{1'b0}}, p00_ff}
                     + {{LW{1'b0}}, p01_ff, {LW{1'b0}}}
                     + {{LW{1'b0}}, p10_ff, {LW{1'b0}}}
                     + {p11_ff, {DW{1'b0}}};

   always_ff @(posedge clock) begin
      if (stage_en.load_a) begin
         p00_ff <= p00_in;
         p01_ff <= p01_in;
         p10_ff <= p10_in;
         p11_ff <= p11_in;
      end
      if (stage_en.load_b) begin
         product_ff <= product_in;
      end
   end

   assign product = product_ff;

endmodule

### src/mmm_low_mul.sv
module mmm_low_mul (
   input  logic                              clock,
   input  mmm_pkg::stage_en_type             stage_en,
   input  logic [mmm_pkg::DATA_W-1:0]        prod_lo,
   input  logic [mmm_pkg::DATA_W-1:0]        inverse,
   input  logic [mmm_pkg::DATA_W-1:0]        radix_mask,
   output logic [mmm_pkg::DATA_W-1:0]        quotient
);

   localparam int LW = mmm_pkg::LIMB_W;
   localparam int DW = mmm_pkg::DATA_W;

   logic [DW-1:0] p00_ff, p00_in;
   logic [LW-1:0] c01_ff, c10_ff, c01_in, c10_in;
   logic [DW-1:0] x01, x10;
   logic [DW-1:0] quotient_ff, quotient_in;

   // only the low word of the product is kept, so the cross terms need their low limb
   assign p00_in = DW'(prod_lo[LW-1:0])  * DW'(inverse[LW-1:0]);
   assign x01    = DW'(prod_lo[LW-1:0])  * DW'(inverse[DW-1:LW]);
   assign x10    = DW'(prod_lo[DW-1:LW]) * DW'(inverse[LW-1:0]);
   assign c01_in = x01[LW-1:0];
   assign c10_in = x10[LW-1:0];

   assign quotient_in = (p00_ff + {c01_ff + c10_ff, {LW{1'b0}}}) & radix_mask;

   always_ff @(posedge clock) begin
      if (stage_en.load_a) begin
         p00_ff <= p00_in;
         c01_ff <= c01_in;
         c10_ff <= c10_in;
      end
      if (stage_en.load_b) begin
         quotient_ff <= quotient_in;
      end
   end

   assign quotient = quotient_ff;

endmodule

### src/mmm_reduce.sv
module mmm_reduce (
   input  logic                              clock,
   input  mmm_pkg::stage_en_type             stage_en,
   input  logic [mmm_pkg::SUM_W-1:0]         sum,
   input  logic [mmm_pkg::SHIFT_W-1:0]       radix_k,
   input  logic [mmm_pkg::DATA_W-1:0]        modulus,
   output logic [mmm_pkg::DATA_W-1:0]        result
);

   localparam int DW = mmm_pkg::DATA_W;
   localparam int SW = mmm_pkg::SUM_W;

   logic [SW-1:0] m_ff, m_in;
   logic          over;
   logic [DW-1:0] result_ff, result_in;

   assign m_in = sum >> radix_k;

   // one conditional subtraction against the full quotient
   assign over      = (|m_ff[SW-1:DW]) || (m_ff[DW-1:0] >= modulus);
   assign result_in = (over ? (m_ff[DW-1:0] - modulus) : m_ff[DW-1:0]) & mmm_pkg::WIDTH_MASK;

   always_ff @(posedge clock) begin
      if (stage_en.load_a) begin
         m_ff <= m_in;
      end
      if (stage_en.load_b) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

### src/montgomery_modular_multiply.sv
// montgomery multiply, a*b*2^-k mod p, nine register stages built from 32x32 multipliers
// a result word shows on rsp when its request word reaches the last stage
// throughput: one word per cycle without stalls; a stage holds its word while the next
//    is full and stuck, so bubbles close up and req_tready drops only with all nine full
// reset: synchronous, clears all stage valid bits and loads modulus 1, inverse 0, k 64
module montgomery_modular_multiply (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [2*mmm_pkg::DATA_W-1:0]       req_tdata,  // multiplicand, multiplier
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [mmm_pkg::DATA_W-1:0]         rsp_tdata,  // reduced_product
   input  logic                               csr_we,
   input  logic [1:0]                         csr_index,
   input  logic [mmm_pkg::DATA_W-1:0]         csr_wdata
);

   localparam int DW = mmm_pkg::DATA_W;
   localparam int PW = mmm_pkg::PROD_W;
   localparam int SW = mmm_pkg::SUM_W;
   localparam int KW = mmm_pkg::SHIFT_W;
   localparam int NS = mmm_pkg::STAGES;

   logic [DW-1:0] modulus_ff, modulus_inverse_ff;
   logic [KW-1:0] shift_bits_ff;
   logic [DW-1:0] p_masked, ninv_masked, a_masked, b_masked, radix_mask;
   logic [KW-1:0] radix_k;

   logic [NS-1:0] valid_ff, valid_in, stage_ready;

   logic [PW-1:0] s_prod, q_prod;
   logic [PW-1:0] s_dly_ff [4];
   logic [DW-1:0] t_word;
   logic [SW-1:0] sum_ff, sum_in;
   logic [DW-1:0] result;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff         <= mmm_pkg::MODULUS_RESET;
         modulus_inverse_ff <= mmm_pkg::MODULUS_INVERSE_RESET;
         shift_bits_ff      <= mmm_pkg::SHIFT_BITS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            mmm_pkg::CSR_MODULUS:         modulus_ff         <= csr_wdata;
            mmm_pkg::CSR_MODULUS_INVERSE: modulus_inverse_ff <= csr_wdata;
            mmm_pkg::CSR_SHIFT_BITS:      shift_bits_ff      <= csr_wdata[KW-1:0];
            default: ;
         endcase
      end
   end

   assign p_masked    = modulus_ff & mmm_pkg::WIDTH_MASK;
   assign ninv_masked = modulus_inverse_ff & mmm_pkg::WIDTH_MASK;
   assign a_masked    = req_tdata[DW-1:0] & mmm_pkg::WIDTH_MASK;
   assign b_masked    = req_tdata[2*DW-1:DW] & mmm_pkg::WIDTH_MASK;
   assign radix_k     = (shift_bits_ff > mmm_pkg::WIDTH_K) ? mmm_pkg::WIDTH_K : shift_bits_ff;
   // at k = 64 the shift wraps to zero and the subtraction yields all ones
   assign radix_mask  = (DW'(1) << radix_k) - DW'(1);

   // a stage takes a new word when it is empty or its word moves on
   always_comb begin
      stage_ready[NS-1] = !valid_ff[NS-1] || rsp_tready;
      for (int i = NS - 2; i >= 0; i--) begin
         stage_ready[i] = !valid_ff[i] || stage_ready[i+1];
      end
   end

   assign valid_in = {valid_ff[NS-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < NS; i++) begin
            if (stage_ready[i]) begin
               valid_ff[i] <= valid_in[i];
            end
         end
      end
   end

   // stages 0 and 1: s = a * b
   mmm_wide_mul u_mul_ab (
      .clock    (clock),
      .stage_en ('{load_a: stage_ready[0], load_b: stage_ready[1]}),
      .op_x     (a_masked),
      .op_y     (b_masked),
      .product  (s_prod)
   );

   // stages 2 and 3: t = (s * n') mod 2^k
   mmm_low_mul u_mul_t (
      .clock      (clock),
      .stage_en   ('{load_a: stage_ready[2], load_b: stage_ready[3]}),
      .prod_lo    (s_prod[DW-1:0]),
      .inverse    (ninv_masked),
      .radix_mask (radix_mask),
      .quotient   (t_word)
   );

   // stages 4 and 5: q = t * p
   mmm_wide_mul u_mul_tp (
      .clock    (clock),
      .stage_en ('{load_a: stage_ready[4], load_b: stage_ready[5]}),
      .op_x     (t_word),
      .op_y     (p_masked),
      .product  (q_prod)
   );

   // s rides alongside stages 2 to 5
   always_ff @(posedge clock) begin
      if (stage_ready[2]) s_dly_ff[0] <= s_prod;
      if (stage_ready[3]) s_dly_ff[1] <= s_dly_ff[0];
      if (stage_ready[4]) s_dly_ff[2] <= s_dly_ff[1];
      if (stage_ready[5]) s_dly_ff[3] <= s_dly_ff[2];
   end

   // stage 6: full sum keeps its carry bit
   assign sum_in = {1'b0, s_dly_ff[3]} + {1'b0, q_prod};

   always_ff @(posedge clock) begin
      if (stage_ready[6]) begin
         sum_ff <= sum_in;
      end
   end

   // stages 7 and 8: shift by k, then final subtraction
   mmm_reduce u_reduce (
      .clock    (clock),
      .stage_en ('{load_a: stage_ready[7], load_b: stage_ready[8]}),
      .sum      (sum_ff),
      .radix_k  (radix_k),
      .modulus  (p_masked),
      .result   (result)
   );

   assign req_tready = stage_ready[0];
   assign rsp_tvalid = valid_ff[NS-1];
   assign rsp_tdata  = result;

endmodule

### src/mmm_checker.sv
module mmm_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tvalid,
   input logic                          req_tready,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [mmm_pkg::DATA_W-1:0]    rsp_tdata
);

   // a stalled result word stays and holds its value
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result word dropped or changed");

   // reset empties the pipeline
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result word valid right after reset");

   // the request side is held off only when the result side is stalled
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("request held off while result side can drain");

   // with the result side draining, a request is never refused
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && rsp_tready |-> req_tready)
      else $error("request refused although result side is ready");

endmodule

bind montgomery_modular_multiply mmm_checker u_mmm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

### verif/tb_montgomery_modular_multiply.sv
`timescale 1ns / 100ps

module tb_montgomery_modular_multiply;

   localparam int DATA_W = mmm_pkg::DATA_W;
   localparam int PROD_W = mmm_pkg::PROD_W;
   localparam int SUM_W = mmm_pkg::SUM_W;
   localparam int SHIFT_W = mmm_pkg::SHIFT_W;
   localparam int WIDTH = mmm_pkg::WIDTH;
   localparam int STAGES = mmm_pkg::STAGES;
   localparam logic [DATA_W-1:0] WIDTH_MASK = mmm_pkg::WIDTH_MASK;
   localparam logic [SHIFT_W-1:0] WIDTH_K = mmm_pkg::WIDTH_K;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_PHASES = 12;
   localparam int WORDS_PER_PHASE = 60;
   localparam logic [1:0] CSR_SPARE_INDEX = 2'd3;
   localparam logic [DATA_W-1:0] PRIME_64 = 64'hFFFF_FFFF_FFFF_FFC5;
   localparam logic [DATA_W-1:0] ALL_ONES = {DATA_W{1'b1}};

   typedef struct {
      logic [DATA_W-1:0] multiplicand;
      logic [DATA_W-1:0] multiplier;
   } operand_pair_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [2*DATA_W-1:0]   req_tdata = '0;  // multiplicand, multiplier
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [DATA_W-1:0]     rsp_tdata;       // reduced_product
   logic                  csr_we = 1'b0;
   logic [1:0]            csr_index = mmm_pkg::CSR_MODULUS;
   logic [DATA_W-1:0]     csr_wdata = '0;

   // local copy of the register file
   logic [DATA_W-1:0]     cfg_modulus = mmm_pkg::MODULUS_RESET;
   logic [DATA_W-1:0]     cfg_inverse = mmm_pkg::MODULUS_INVERSE_RESET;
   logic [SHIFT_W-1:0]    cfg_shift = mmm_pkg::SHIFT_BITS_RESET;

   operand_pair_type      pending_pairs[$];
   operand_pair_type      next_pair;
   logic [DATA_W-1:0]     expected_products[$];

   int unsigned           send_idle_pct = 28;
   int unsigned           recv_idle_pct = 51;
   int unsigned           error_count = 0;
   int unsigned           products_checked = 0;
   int unsigned           settings_used = 1;
   int unsigned           stalled_cycles = 0;

   montgomery_modular_multiply dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // a*b*2^-k mod p with a single conditional subtraction, 129-bit intermediate sum
   function automatic logic [DATA_W-1:0] redc_product(input logic [DATA_W-1:0] a_in,
                                                      input logic [DATA_W-1:0] b_in);
      logic [DATA_W-1:0] a, b, p, ninv, t, kmask;
      logic [PROD_W-1:0] s, q;
      logic [SUM_W-1:0]  total, m;
      int unsigned       k;
      a = a_in & WIDTH_MASK;
      b = b_in & WIDTH_MASK;
      p = cfg_modulus & WIDTH_MASK;
      ninv = cfg_inverse & WIDTH_MASK;
      k = (cfg_shift > WIDTH_K) ? WIDTH : cfg_shift;
      kmask = (k >= DATA_W) ? ALL_ONES : ((DATA_W'(1) << k) - DATA_W'(1));
      s = PROD_W'(a) * PROD_W'(b);
      t = (s[DATA_W-1:0] * ninv) & kmask;
      q = PROD_W'(t) * PROD_W'(p);
      total = SUM_W'(s) + SUM_W'(q);
      m = total >> k;
      if (m >= SUM_W'(p)) begin
         return (m[DATA_W-1:0] - p) & WIDTH_MASK;
      end
      return m[DATA_W-1:0] & WIDTH_MASK;
   endfunction

   // -p^-1 mod 2^64 by newton iteration, p odd
   function automatic logic [DATA_W-1:0] negated_inverse(input logic [DATA_W-1:0] p);
      logic [DATA_W-1:0] x;
      x = p;
      repeat (6) x = x * (DATA_W'(2) - p * x);
      return -x;
   endfunction

   function automatic logic [DATA_W-1:0] random_word();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [DATA_W-1:0] random_operand(input logic [DATA_W-1:0] p);
      if (p == '0) begin
         return random_word();
      end
      case ($urandom_range(11))
         0: return '0;
         1: return p - 1;
         2: return random_word();  // not reduced
         3: return (random_word() >> $urandom_range(DATA_W - 1)) % p;
         default: return random_word() % p;
      endcase
   endfunction

   task automatic queue_pair(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b);
      operand_pair_type pair;
      pair.multiplicand = a;
      pair.multiplier = b;
      pending_pairs.push_back(pair);
   endtask

   // sender holds off until every result is back and the pipeline has emptied
   task automatic wait_idle();
      while (pending_pairs.size() != 0 || req_tvalid || expected_products.size() != 0)
         @(posedge clock);
      repeat (STAGES + 2) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] index, input logic [DATA_W-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      case (index)
         mmm_pkg::CSR_MODULUS:         cfg_modulus = value;
         mmm_pkg::CSR_MODULUS_INVERSE: cfg_inverse = value;
         mmm_pkg::CSR_SHIFT_BITS:      cfg_shift = value[SHIFT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_config(input logic [DATA_W-1:0] p, input logic [DATA_W-1:0] ninv,
                               input logic [SHIFT_W-1:0] k);
      wait_idle();
      csr_write(mmm_pkg::CSR_MODULUS, p);
      csr_write(mmm_pkg::CSR_MODULUS_INVERSE, ninv);
      // upper bits of the shift word are ignored by the block
      csr_write(mmm_pkg::CSR_SHIFT_BITS, (random_word() << SHIFT_W) | DATA_W'(k));
      if ($urandom_range(3) == 0) begin
         csr_write(CSR_SPARE_INDEX, random_word());
      end
      @(posedge clock);
      csr_we <= 1'b0;
      settings_used++;
      @(negedge clock);
   endtask

   task automatic random_config();
      logic [DATA_W-1:0]  p, ninv, kmask;
      logic [SHIFT_W-1:0] k;
      int unsigned        bits;
      bits = $urandom_range(1, DATA_W);
      p = (random_word() >> (DATA_W - bits)) | (DATA_W'(1) << (bits - 1)) | DATA_W'(1);
      k = ($urandom_range(3) == 0) ? SHIFT_W'(DATA_W) : SHIFT_W'($urandom_range(1, DATA_W));
      kmask = (k >= DATA_W) ? ALL_ONES : ((DATA_W'(1) << k) - DATA_W'(1));
      ninv = (negated_inverse(p) & kmask) | (random_word() & ~kmask);
      case ($urandom_range(9))
         0: k = '0;
         1: k = SHIFT_W'($urandom_range(DATA_W + 1, 127));
         2: p = '0;
         3: begin
            p = random_word() & ~DATA_W'(1);
            ninv = random_word();
         end
         4: ninv = random_word();
         default: ;
      endcase
      apply_config(p, ninv, k);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_products.push_back(redc_product(req_tdata[DATA_W-1:0],
                                                     req_tdata[2*DATA_W-1:DATA_W]));
         end
         if (!req_tvalid || req_tready) begin
            if (pending_pairs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_pair = pending_pairs.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {next_pair.multiplier, next_pair.multiplicand};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_products.size() == 0) begin
               $error("reduced_product: unexpected word %h", rsp_tdata);
               error_count++;
            end else begin
               if (rsp_tdata !== expected_products[0]) begin
                  $error("reduced_product: expected %h, got %h", expected_products[0],
                         rsp_tdata);
                  error_count++;
               end
               void'(expected_products.pop_front());
               products_checked++;
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            stalled_cycles <= 0;
         end else begin
            stalled_cycles <= stalled_cycles + 1;
         end
         if (stalled_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: p = 1, n' = 0, k = 64
      queue_pair('0, '0);
      queue_pair(ALL_ONES, ALL_ONES);
      queue_pair(64'd1, 64'd1);

      apply_config(PRIME_64, negated_inverse(PRIME_64), SHIFT_W'(64));
      queue_pair('0, '0);
      queue_pair(PRIME_64 - 1, PRIME_64 - 1);
      queue_pair(64'd1, PRIME_64 - 1);
      queue_pair(ALL_ONES, ALL_ONES);
      queue_pair(64'd1, 64'd1);

      apply_config(ALL_ONES, negated_inverse(ALL_ONES), SHIFT_W'(64));
      queue_pair(ALL_ONES - 1, ALL_ONES - 1);
      queue_pair(ALL_ONES, ALL_ONES);

      // radix exponent zero
      apply_config(PRIME_64, negated_inverse(PRIME_64), '0);
      queue_pair(PRIME_64 - 1, PRIME_64 - 1);
      queue_pair(ALL_ONES, ALL_ONES);
      queue_pair(random_word(), random_word());

      // exponent above the width saturates
      apply_config(PRIME_64, negated_inverse(PRIME_64), {SHIFT_W{1'b1}});
      queue_pair(PRIME_64 - 1, PRIME_64 - 2);
      queue_pair(random_word() % PRIME_64, random_word() % PRIME_64);

      // zero modulus
      apply_config('0, random_word(), SHIFT_W'(64));
      queue_pair(ALL_ONES, ALL_ONES);
      queue_pair(random_word(), random_word());

      // even modulus with arbitrary inverse
      apply_config(64'h8000_0000_0000_0000, random_word(), SHIFT_W'(64));
      queue_pair(ALL_ONES, 64'h7FFF_FFFF_FFFF_FFFF);
      queue_pair(random_word(), random_word());

      // wrong inverse
      apply_config(PRIME_64, random_word(), SHIFT_W'(64));
      queue_pair(PRIME_64 - 1, PRIME_64 - 1);
      queue_pair(random_word(), random_word());

      // smallest nonzero exponent
      apply_config(64'd3, negated_inverse(64'd3) | 64'hFFFF_0000_0000_0000, SHIFT_W'(1));
      queue_pair(64'd2, 64'd2);
      queue_pair(64'd1, 64'd2);

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         random_config();
         if (phase == RANDOM_PHASES / 3) begin
            send_idle_pct = 51;
            recv_idle_pct = 28;
         end else if (phase == 2 * RANDOM_PHASES / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         for (int n = 0; n < WORDS_PER_PHASE; n++) begin
            if (phase % 2 == 1 && n == WORDS_PER_PHASE / 2) begin
               wait_idle();
               @(negedge clock);
            end
            queue_pair(random_operand(cfg_modulus), random_operand(cfg_modulus));
         end
      end

      wait_idle();
      repeat (2 * STAGES) @(posedge clock);
      if (expected_products.size() != 0) begin
         $error("reduced_product: %0d results never arrived", expected_products.size());
         error_count++;
      end
      $display("%0d montgomery products compared over %0d register settings", products_checked,
               settings_used);
      $display("settings included k of 0, 1, 64 and oversized, zero and even moduli, bad n'");
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
